// ===== sv/frx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared types and constants: parse phases, status codes, header and footer
// words, and the result word passed between the parser and the output stage.
// ----------------------------------------------------------------------------
package frx_pkg;

    localparam logic [15:0] HEADER_WORD = 16'hCDAB;
    localparam logic [15:0] FOOTER_WORD = 16'hBADC;

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK  = 3'd4,
        PH_FTR0 = 3'd5,
        PH_FTR1 = 3'd6
    } phase_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_HEADER = 3'd2;
    localparam logic [2:0] ST_LONG   = 3'd3;
    localparam logic [2:0] ST_FOOTER = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [2:0] frame_status;
        logic [7:0] frame_length;
    } res_t;

endpackage

// ===== sv/frx_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one received byte per word.
// ----------------------------------------------------------------------------
interface frx_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/frx_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying payload bytes and frame status words.
// ----------------------------------------------------------------------------
interface frx_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] frame_status;
    logic [7:0] frame_length;

    modport source (output valid, output kind, output payload_byte,
                    output frame_status, output frame_length, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input frame_status, input frame_length, output ready);
endinterface

// ===== sv/frx_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel writing the max_payload register.
// ----------------------------------------------------------------------------
interface frx_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink   (input valid, input max_payload, output ready);
endinterface

// ===== sv/frx_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver input stage
// Registers one received byte and hands it to the parser when the output
// stage has room.
// ----------------------------------------------------------------------------
module frx_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    frx_rx_if.sink        rx,
    input  logic          out_free,
    output logic          step,
    output logic [7:0]    byte_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign step     = valid_reg && out_free;
    assign rx.ready = !valid_reg || step;
    assign load     = rx.valid && rx.ready;
    assign byte_q   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

endmodule

// ===== sv/frx_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver parser
// Phase state machine: header pair, length, payload with running XOR,
// check byte, footer pair and the closing status.
// ----------------------------------------------------------------------------
module frx_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         max_payload,
    output logic               emit,
    output frx_pkg::res_t      res
);

    frx_pkg::phase_t phase_reg;
    frx_pkg::phase_t phase_next;
    logic [7:0]      pair_reg;
    logic [7:0]      pair_next;
    logic [7:0]      length_reg;
    logic [7:0]      length_next;
    logic [7:0]      seen_reg;
    logic [7:0]      seen_next;
    logic [7:0]      xor_reg;
    logic [7:0]      xor_next;
    logic [7:0]      check_reg;
    logic [7:0]      check_next;
    logic [15:0]     pair_word;
    logic [7:0]      seen_inc;

    assign pair_word = {rx_byte, pair_reg};
    assign seen_inc  = seen_reg + 8'd1;

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        pair_next   = pair_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        xor_next    = xor_reg;
        check_next  = check_reg;
        case (phase_reg)
            frx_pkg::PH_HDR1:
            begin
                if (pair_word != frx_pkg::HEADER_WORD)
                begin
                    phase_next = frx_pkg::PH_HDR0;
                end
                else
                begin
                    phase_next = frx_pkg::PH_LEN;
                end
            end
            frx_pkg::PH_LEN:
            begin
                length_next = rx_byte;
                seen_next   = 8'd0;
                xor_next    = 8'd0;
                if (rx_byte > max_payload)
                begin
                    phase_next = frx_pkg::PH_HDR0;
                end
                else if (rx_byte == 8'd0)
                begin
                    phase_next = frx_pkg::PH_CHK;
                end
                else
                begin
                    phase_next = frx_pkg::PH_DATA;
                end
            end
            frx_pkg::PH_DATA:
            begin
                xor_next  = xor_reg ^ rx_byte;
                seen_next = seen_inc;
                if (seen_inc >= length_reg)
                begin
                    phase_next = frx_pkg::PH_CHK;
                end
            end
            frx_pkg::PH_CHK:
            begin
                check_next = rx_byte;
                phase_next = frx_pkg::PH_FTR0;
            end
            frx_pkg::PH_FTR0:
            begin
                pair_next  = rx_byte;
                phase_next = frx_pkg::PH_FTR1;
            end
            frx_pkg::PH_FTR1:
            begin
                phase_next = frx_pkg::PH_HDR0;
            end
            default:
            begin
                // first header byte, also taken for the unused phase code
                pair_next  = rx_byte;
                phase_next = frx_pkg::PH_HDR1;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        emit             = 1'b0;
        res.kind         = frx_pkg::KIND_STATUS;
        res.payload_byte = 8'd0;
        res.frame_status = frx_pkg::ST_OK;
        res.frame_length = 8'd0;
        case (phase_reg)
            frx_pkg::PH_HDR1:
            begin
                if (pair_word != frx_pkg::HEADER_WORD)
                begin
                    emit             = 1'b1;
                    res.frame_status = frx_pkg::ST_HEADER;
                end
            end
            frx_pkg::PH_LEN:
            begin
                if (rx_byte > max_payload)
                begin
                    emit             = 1'b1;
                    res.frame_status = frx_pkg::ST_LONG;
                    res.frame_length = rx_byte;
                end
            end
            frx_pkg::PH_DATA:
            begin
                emit             = 1'b1;
                res.kind         = frx_pkg::KIND_PAYLOAD;
                res.payload_byte = rx_byte;
            end
            frx_pkg::PH_FTR1:
            begin
                emit = 1'b1;
                if (pair_word != frx_pkg::FOOTER_WORD)
                begin
                    res.frame_status = frx_pkg::ST_FOOTER;
                    res.frame_length = length_reg;
                end
                else if (length_reg == 8'd0)
                begin
                    res.frame_status = frx_pkg::ST_EMPTY;
                end
                else if (xor_reg != check_reg)
                begin
                    res.frame_status = frx_pkg::ST_CHECK;
                    res.frame_length = length_reg;
                end
                else
                begin
                    res.frame_status = frx_pkg::ST_OK;
                    res.frame_length = length_reg;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= frx_pkg::PH_HDR0;
            pair_reg   <= 8'd0;
            length_reg <= 8'd0;
            seen_reg   <= 8'd0;
            xor_reg    <= 8'd0;
            check_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pair_reg   <= pair_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
            xor_reg    <= xor_next;
            check_reg  <= check_next;
        end
    end

    a_payload_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.kind == frx_pkg::KIND_PAYLOAD) |-> phase_reg == frx_pkg::PH_DATA)
        else $error("payload word outside the data phase");

    a_footer_restarts_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == frx_pkg::PH_FTR1) |=> phase_reg == frx_pkg::PH_HDR0)
        else $error("hunt did not restart after footer");

    a_long_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == frx_pkg::PH_LEN && rx_byte > max_payload)
        |-> (emit && res.frame_status == frx_pkg::ST_LONG && res.frame_length == rx_byte))
        else $error("oversize length not reported");

    a_data_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == frx_pkg::PH_DATA) |-> (seen_reg < length_reg))
        else $error("payload count ran past the length");

endmodule

// ===== sv/frx_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver output stage
// Result register in front of the result channel; takes a new word in the
// same cycle that the held one is taken.
// ----------------------------------------------------------------------------
module frx_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           emit,
    input  frx_pkg::res_t  res,
    output logic           out_free,
    frx_res_if.source      out
);

    logic          valid_reg;
    logic          valid_next;
    frx_pkg::res_t res_reg;
    logic          load;

    assign out_free = !valid_reg || out.ready;
    assign load     = step && emit;

    assign out.valid        = valid_reg;
    assign out.kind         = res_reg.kind;
    assign out.payload_byte = res_reg.payload_byte;
    assign out.frame_status = res_reg.frame_status;
    assign out.frame_length = res_reg.frame_length;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== sv/framed_packet_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver
// Deframes AB CD / length / payload / check / DC BA frames from a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per clock on rx and can keep that rate indefinitely as long
// as res is drained. Each byte is held in the input register, is parsed in
// a single pass, and any result lands in the result register, which drives
// res. Payload bytes come out as they arrive (kind 0); after the footer pair
// one status word follows (kind 1). A bad header pair or an oversize length
// is reported at once and the header hunt restarts. Write max_payload through
// cfg only while the block is idle; it applies from the next length byte.
module framed_packet_receiver (
    input  logic       clk,
    input  logic       rst_n,
    frx_rx_if.sink     rx,
    frx_res_if.source  res,
    frx_cfg_if.sink    cfg
);

    logic          step;
    logic [7:0]    byte_q;
    logic          out_free;
    logic          emit;
    frx_pkg::res_t parse_res;
    logic [7:0]    max_payload_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= frx_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_payload_reg <= cfg.max_payload;
        end
    end

    frx_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .out_free (out_free),
        .step     (step),
        .byte_q   (byte_q)
    );

    frx_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (byte_q),
        .max_payload (max_payload_reg),
        .emit        (emit),
        .res         (parse_res)
    );

    frx_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .emit     (emit),
        .res      (parse_res),
        .out_free (out_free),
        .out      (res)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Feeds byte streams of good, damaged and oversize frames through the rx
// channel under several max_payload limits and idle patterns. A local parser
// tracks the frame state, predicts every payload word and frame status, and
// the monitor compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_LIMIT   = 100;

    localparam logic [7:0] HDR_LO = frx_pkg::HEADER_WORD[7:0];
    localparam logic [7:0] HDR_HI = frx_pkg::HEADER_WORD[15:8];
    localparam logic [7:0] FTR_LO = frx_pkg::FOOTER_WORD[7:0];
    localparam logic [7:0] FTR_HI = frx_pkg::FOOTER_WORD[15:8];

    // bad pairs (one ending in the first header byte), good frame, empty
    // frame with a stray check byte, and a frame with a wrong check byte
    localparam logic [7:0] OPENING_BYTES [24] = '{
        8'h00, 8'hFF,
        8'h00, HDR_LO,
        HDR_LO, HDR_HI, 8'h01, 8'hFF, 8'hFF, FTR_LO, FTR_HI,
        HDR_LO, HDR_HI, 8'h00, 8'h5A, FTR_LO, FTR_HI,
        HDR_LO, HDR_HI, 8'h01, 8'h00, 8'h01, FTR_LO, FTR_HI
    };

    // with max_payload at zero: oversize by one, then an empty frame whose
    // broken footer has to win over the empty status
    localparam logic [7:0] ZERO_LIMIT_BYTES [9] = '{
        HDR_LO, HDR_HI, 8'h01,
        HDR_LO, HDR_HI, 8'h00, 8'h00, FTR_LO, 8'h00
    };

    logic clk;
    logic rst_n;

    frx_rx_if  rx_bus ();
    frx_res_if res_bus ();
    frx_cfg_if cfg_bus ();

    framed_packet_receiver u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // parser copy
    frx_pkg::phase_t prs_phase     = frx_pkg::PH_HDR0;
    logic [7:0]      max_payload_q = frx_pkg::MAX_PAYLOAD_RESET;
    logic [7:0]      pair_lo       = 8'h00;
    logic [7:0]      frm_len       = 8'h00;
    logic [7:0]      data_cnt      = 8'h00;
    logic [7:0]      data_xor      = 8'h00;
    logic [7:0]      chk_byte      = 8'h00;

    logic [7:0]    rx_pend_q [$];
    frx_pkg::res_t expect_q [$];

    int queued_cnt    = 0;
    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;
    int rx_idle_pct   = 0;
    int res_stall_pct = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // advance the parser by one accepted byte and queue any result it makes
    task automatic parse_byte(input logic [7:0] b);
        frx_pkg::res_t r;
        logic          emit;
        logic [15:0]   pair;
        r    = '0;
        emit = 1'b0;
        pair = {b, pair_lo};
        case (prs_phase)
            frx_pkg::PH_HDR1:
            begin
                if (pair != frx_pkg::HEADER_WORD)
                begin
                    prs_phase      = frx_pkg::PH_HDR0;
                    emit           = 1'b1;
                    r.kind         = frx_pkg::KIND_STATUS;
                    r.frame_status = frx_pkg::ST_HEADER;
                end
                else
                begin
                    prs_phase = frx_pkg::PH_LEN;
                end
            end
            frx_pkg::PH_LEN:
            begin
                frm_len  = b;
                data_cnt = 8'h00;
                data_xor = 8'h00;
                if (b > max_payload_q)
                begin
                    prs_phase      = frx_pkg::PH_HDR0;
                    emit           = 1'b1;
                    r.kind         = frx_pkg::KIND_STATUS;
                    r.frame_status = frx_pkg::ST_LONG;
                    r.frame_length = b;
                end
                else
                begin
                    prs_phase = (b == 8'h00) ? frx_pkg::PH_CHK : frx_pkg::PH_DATA;
                end
            end
            frx_pkg::PH_DATA:
            begin
                data_xor = data_xor ^ b;
                data_cnt = data_cnt + 8'd1;
                if (data_cnt >= frm_len)
                    prs_phase = frx_pkg::PH_CHK;
                emit           = 1'b1;
                r.kind         = frx_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
            end
            frx_pkg::PH_CHK:
            begin
                chk_byte  = b;
                prs_phase = frx_pkg::PH_FTR0;
            end
            frx_pkg::PH_FTR0:
            begin
                pair_lo   = b;
                prs_phase = frx_pkg::PH_FTR1;
            end
            frx_pkg::PH_FTR1:
            begin
                prs_phase      = frx_pkg::PH_HDR0;
                emit           = 1'b1;
                r.kind         = frx_pkg::KIND_STATUS;
                r.frame_length = frm_len;
                if (pair != frx_pkg::FOOTER_WORD)
                begin
                    r.frame_status = frx_pkg::ST_FOOTER;
                end
                else if (frm_len == 8'h00)
                begin
                    r.frame_status = frx_pkg::ST_EMPTY;
                    r.frame_length = 8'h00;
                end
                else if (data_xor != chk_byte)
                begin
                    r.frame_status = frx_pkg::ST_CHECK;
                end
                else
                begin
                    r.frame_status = frx_pkg::ST_OK;
                end
            end
            default:
            begin
                pair_lo   = b;
                prs_phase = frx_pkg::PH_HDR1;
            end
        endcase
        if (emit)
            expect_q.push_back(r);
    endtask

    task automatic check_result();
        frx_pkg::res_t want;
        if (expect_q.size() == 0)
        begin
            report_mismatch($sformatf("word with nothing pending: kind %0d byte %02h status %0d len %0d",
                                      res_bus.kind, res_bus.payload_byte,
                                      res_bus.frame_status, res_bus.frame_length));
        end
        else
        begin
            want = expect_q.pop_front();
            if (res_bus.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", res_bus.kind, want.kind));
            if (res_bus.payload_byte !== want.payload_byte)
                report_mismatch($sformatf("payload_byte %02h, want %02h",
                                          res_bus.payload_byte, want.payload_byte));
            if (res_bus.frame_status !== want.frame_status)
                report_mismatch($sformatf("frame_status %0d, want %0d",
                                          res_bus.frame_status, want.frame_status));
            if (res_bus.frame_length !== want.frame_length)
                report_mismatch($sformatf("frame_length %0d, want %0d",
                                          res_bus.frame_length, want.frame_length));
        end
    endtask

    // rx driver: hold the word until taken, then maybe idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_bus.valid <= 1'b0;
        end
        else
        begin
            if (rx_bus.valid && rx_bus.ready)
                parse_byte(rx_bus.rx_byte);
            if (!rx_bus.valid || rx_bus.ready)
            begin
                if (rx_pend_q.size() != 0 && $urandom_range(99) >= rx_idle_pct)
                begin
                    rx_bus.valid   <= 1'b1;
                    rx_bus.rx_byte <= rx_pend_q.pop_front();
                end
                else
                begin
                    rx_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
                check_result();
            res_bus.ready <= ($urandom_range(99) >= res_stall_pct);
        end
    end

    task automatic put_byte(input logic [7:0] b);
        rx_pend_q.push_back(b);
        queued_cnt++;
    endtask

    task automatic put_header();
        put_byte(HDR_LO);
        put_byte(HDR_HI);
    endtask

    // length byte onward: payload, check byte, footer pair
    task automatic put_frame_body(input int len, input bit good_chk, input bit good_ftr);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] lo;
        logic [7:0] hi;
        sum = 8'h00;
        put_byte(8'(len));
        for (int i = 0; i < len; i++)
        begin
            b   = 8'($urandom);
            sum = sum ^ b;
            put_byte(b);
        end
        put_byte(good_chk ? sum : sum ^ 8'($urandom_range(255, 1)));
        lo = FTR_LO;
        hi = FTR_HI;
        if (!good_ftr)
        begin
            if ($urandom_range(1) == 0)
                lo = lo ^ 8'($urandom_range(255, 1));
            else
                hi = hi ^ 8'($urandom_range(255, 1));
        end
        put_byte(lo);
        put_byte(hi);
    endtask

    // every unit leaves the parser hunting on a pair boundary
    task automatic put_traffic(input int n_bytes);
        int         stop_at;
        int         pick;
        int         cap;
        int         len;
        logic [7:0] b0;
        logic [7:0] b1;
        stop_at = queued_cnt + n_bytes;
        while (queued_cnt < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                b0 = 8'($urandom);
                b1 = 8'($urandom);
                if ({b1, b0} == frx_pkg::HEADER_WORD)
                    b1 = ~b1;
                put_byte(b0);
                put_byte(b1);
            end
            else if (pick < 16)
            begin
                if ($urandom_range(1) == 0)
                begin
                    b1 = 8'($urandom);
                    if (b1 == HDR_HI)
                        b1 = ~b1;
                    put_byte(HDR_LO);
                    put_byte(b1);
                end
                else
                begin
                    b0 = 8'($urandom);
                    if (b0 == HDR_LO)
                        b0 = ~b0;
                    put_byte(b0);
                    put_byte(HDR_HI);
                end
            end
            else if (pick < 24 && max_payload_q != 8'hFF)
            begin
                put_header();
                put_byte(8'($urandom_range(255, int'(max_payload_q) + 1)));
            end
            else
            begin
                cap = (max_payload_q > 8'd12) ? 12 : int'(max_payload_q);
                len = $urandom_range(cap, 0);
                if ($urandom_range(19) == 0 && max_payload_q <= 8'd40)
                    len = max_payload_q;
                put_header();
                put_frame_body(len, $urandom_range(99) >= 20, $urandom_range(99) >= 10);
            end
        end
    endtask

    task automatic drain_rx();
        while (rx_pend_q.size() != 0 || rx_bus.valid)
            @(posedge clk);
    endtask

    // hold until every predicted word is back and the pipeline is empty
    task automatic wait_idle();
        drain_rx();
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // feed bytes one at a time until the parser wants a length byte
    task automatic align_to_length();
        while (prs_phase != frx_pkg::PH_LEN)
        begin
            case (prs_phase)
                frx_pkg::PH_HDR0: put_byte(HDR_LO);
                frx_pkg::PH_HDR1: put_byte(HDR_HI);
                default:          put_byte(8'($urandom));
            endcase
            drain_rx();
        end
    endtask

    task automatic write_max_payload(input logic [7:0] value);
        @(posedge clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.max_payload <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        max_payload_q = value;
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        rx_bus.valid        = 1'b0;
        rx_bus.rx_byte      = 8'h00;
        res_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.max_payload = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit, no idling; includes the longest possible frame
        foreach (OPENING_BYTES[i])
            put_byte(OPENING_BYTES[i]);
        put_header();
        put_frame_body(255, 1'b1, 1'b1);
        put_traffic(40);
        wait_idle();

        // zero limit, sender idling
        write_max_payload(8'h00);
        rx_idle_pct = 66;
        foreach (ZERO_LIMIT_BYTES[i])
            put_byte(ZERO_LIMIT_BYTES[i]);
        put_traffic(40);
        wait_idle();

        // change the limit with a header already taken
        align_to_length();
        wait_idle();
        write_max_payload(8'd17);
        rx_idle_pct   = 0;
        res_stall_pct = 66;
        put_frame_body(17, 1'b1, 1'b1);
        put_header();
        put_byte(8'd18);
        put_traffic(50);
        wait_idle();

        write_max_payload(8'hFF);
        rx_idle_pct   = 18;
        res_stall_pct = 18;
        put_traffic(50);
        wait_idle();

        write_max_payload(8'($urandom_range(40, 13)));
        rx_idle_pct   = 0;
        res_stall_pct = 0;
        put_traffic(50);
        wait_idle();

        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/frx_pkg.sv
sv/frx_rx_if.sv
sv/frx_res_if.sv
sv/frx_cfg_if.sv
sv/frx_in_stage.sv
sv/frx_parser.sv
sv/frx_out_stage.sv
sv/framed_packet_receiver.sv
sim/tb.sv
